// File: src/imhq_pkg.sv
// Shared constants and types for the indexed min-heap queue.
package imhq_pkg;

  localparam int HeapDepth     = 1024;
  localparam int IdSpace       = 1024;
  localparam int PriorityWidth = 32;
  localparam int QueueDepth    = 4;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 10;
  localparam int PRIO_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     item_id;
    logic [PRIO_W-1:0]   priority_req;
  } cmd_t;

endpackage

// File: src/imhq_front.sv
// Front end: accepts items into a small command queue.
module imhq_front #(
  parameter int QUEUE_DEPTH = imhq_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  imhq_pkg::cmd_t in_cmd,
  output logic         q_valid,
  input  logic         q_take,
  output imhq_pkg::cmd_t q_cmd
);
  localparam int AW = $clog2(QUEUE_DEPTH);

  imhq_pkg::cmd_t   fifo [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;
  logic             push;
  logic             pop;

  assign in_stall = (fill == (AW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign pop      = q_valid && q_take;
  assign q_cmd    = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// File: src/imhq_back.sv
// Back end: heap sequencer with id, priority, position and presence memories.
module imhq_back #(
  parameter int HEAP_DEPTH     = imhq_pkg::HeapDepth,
  parameter int ID_SPACE       = imhq_pkg::IdSpace,
  parameter int PRIORITY_WIDTH = imhq_pkg::PriorityWidth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_take,
  input  imhq_pkg::cmd_t                 q_cmd,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [imhq_pkg::ID_W-1:0]      out_id,
  output logic [imhq_pkg::PRIO_W-1:0]    out_priority,
  output logic [imhq_pkg::STATUS_W-1:0]  status,
  output logic [imhq_pkg::COUNT_W-1:0]   count
);
  localparam int HA = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int IA = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int PW = PRIORITY_WIDTH;
  localparam int PTR_W = HA + 2;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLEAR  = 5'd1;
  localparam logic [4:0] S_PRES   = 5'd2;
  localparam logic [4:0] S_PRES2  = 5'd3;
  localparam logic [4:0] S_POS    = 5'd4;
  localparam logic [4:0] S_POS2   = 5'd5;
  localparam logic [4:0] S_UPRD   = 5'd6;
  localparam logic [4:0] S_UPWT   = 5'd7;
  localparam logic [4:0] S_UPCMP  = 5'd8;
  localparam logic [4:0] S_DNRD   = 5'd9;
  localparam logic [4:0] S_DNRD2  = 5'd10;
  localparam logic [4:0] S_DNWT   = 5'd11;
  localparam logic [4:0] S_DNCMP  = 5'd12;
  localparam logic [4:0] S_WRCUR  = 5'd13;
  localparam logic [4:0] S_POPRD  = 5'd14;
  localparam logic [4:0] S_POPWT  = 5'd15;
  localparam logic [4:0] S_POPCAP = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;
  localparam logic [4:0] S_UPDRD  = 5'd18;
  localparam logic [4:0] S_UPDWT  = 5'd19;

  logic [IA-1:0]  ids_mem  [HEAP_DEPTH];
  logic [PW-1:0]  prio_mem [HEAP_DEPTH];
  logic [HA-1:0]  pos_mem  [ID_SPACE];
  logic           pres_mem [ID_SPACE];

  logic [4:0]     state;
  logic [CW-1:0]  ecount;
  logic [IA:0]    clr_idx;

  logic [imhq_pkg::ACTION_W-1:0] act;
  logic [IA-1:0]  cid;
  logic [PW-1:0]  cpr;
  logic [HA-1:0]  pos;
  logic [HA-1:0]  child;
  logic [IA-1:0]  oth_id;
  logic [PW-1:0]  oth_pr;
  logic [IA-1:0]  l_id;
  logic [PW-1:0]  l_pr;

  logic [imhq_pkg::ID_W-1:0]     res_id;
  logic [imhq_pkg::PRIO_W-1:0]   res_pr;
  logic [imhq_pkg::STATUS_W-1:0] res_st;

  logic [HA-1:0]  h_raddr;
  logic [IA-1:0]  h_rid;
  logic [PW-1:0]  h_rpr;
  logic           h_we;
  logic [HA-1:0]  h_waddr;
  logic [IA-1:0]  h_wid;
  logic [PW-1:0]  h_wpr;
  logic [IA-1:0]  p_addr;
  logic [HA-1:0]  p_rdata;
  logic           p_we;
  logic [HA-1:0]  p_wdata;
  logic           pr_rdata;
  logic           pr_we;
  logic [IA-1:0]  pr_waddr;
  logic           pr_wdata;

  logic [PTR_W-1:0] lc;
  logic [PTR_W-1:0] ec_ext;
  logic             id_ok;

  always_ff @(posedge clk) begin
    if (h_we) begin
      ids_mem[h_waddr]  <= h_wid;
      prio_mem[h_waddr] <= h_wpr;
    end
    h_rid <= ids_mem[h_raddr];
    h_rpr <= prio_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pos_mem[p_addr] <= p_wdata;
    end
    p_rdata <= pos_mem[p_addr];
  end

  always_ff @(posedge clk) begin
    if (pr_we) begin
      pres_mem[pr_waddr] <= pr_wdata;
    end
    pr_rdata <= pres_mem[cid];
  end

  assign lc     = {1'b0, pos, 1'b1};
  assign ec_ext = PTR_W'(ecount);
  assign id_ok  = (32'(q_cmd.item_id) < 32'(ID_SPACE));
  assign q_take = (state == S_IDLE) && q_valid;

  always_comb begin
    h_raddr  = pos;
    h_we     = 1'b0;
    h_waddr  = pos;
    h_wid    = cid;
    h_wpr    = cpr;
    p_addr   = cid;
    p_we     = 1'b0;
    p_wdata  = pos;
    pr_we    = 1'b0;
    pr_waddr = cid;
    pr_wdata = 1'b0;
    unique case (state)
      S_CLEAR: begin
        pr_we    = 1'b1;
        pr_waddr = clr_idx[IA-1:0];
      end
      S_UPRD:  h_raddr = (pos - 1'b1) >> 1;
      S_DNRD:  h_raddr = lc[HA-1:0];
      S_DNRD2: h_raddr = lc[HA-1:0] + 1'b1;
      S_POPRD: h_raddr = HA'(ecount - 1'b1);
      S_UPDRD: h_raddr = pos;
      S_UPCMP: begin
        if (oth_pr > cpr) begin
          h_we    = 1'b1;
          h_wid   = oth_id;
          h_wpr   = oth_pr;
          p_we    = 1'b1;
          p_addr  = oth_id;
          p_wdata = pos;
        end
      end
      S_DNCMP: begin
        if (child != pos) begin
          h_we    = 1'b1;
          h_wid   = oth_id;
          h_wpr   = oth_pr;
          p_we    = 1'b1;
          p_addr  = oth_id;
          p_wdata = pos;
        end
      end
      S_WRCUR: begin
        h_we    = 1'b1;
        p_we    = 1'b1;
        p_addr  = cid;
        p_wdata = pos;
        if (act != imhq_pkg::ACT_POP) begin
          pr_we    = 1'b1;
          pr_wdata = 1'b1;
        end
      end
      S_POPCAP: begin
        pr_we    = 1'b1;
        pr_waddr = h_rid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      ecount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (IA+1)'(ID_SPACE-1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            act    <= q_cmd.action;
            cid    <= q_cmd.item_id[IA-1:0];
            cpr    <= PW'(q_cmd.priority_req);
            res_id <= '0;
            res_pr <= '0;
            unique case (q_cmd.action)
              imhq_pkg::ACT_POP: begin
                if (ecount == '0) begin
                  res_st <= imhq_pkg::ST_EMPTY;
                  state  <= S_DONE;
                end else begin
                  res_st <= imhq_pkg::ST_OK;
                  pos    <= '0;
                  state  <= S_POPRD;
                end
              end
              imhq_pkg::ACT_PUSH, imhq_pkg::ACT_UPDATE: begin
                if (!id_ok) begin
                  res_st <= imhq_pkg::ST_UNKNOWN;
                  state  <= S_DONE;
                end else begin
                  res_st <= imhq_pkg::ST_OK;
                  state  <= S_PRES;
                end
              end
              default: begin
                res_st <= imhq_pkg::ST_OK;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_PRES: state <= S_PRES2;
        S_PRES2: begin
          if (pr_rdata) begin
            state <= S_POS;
          end else if (act == imhq_pkg::ACT_UPDATE) begin
            res_st <= imhq_pkg::ST_UNKNOWN;
            state  <= S_DONE;
          end else if (32'(ecount) >= 32'(HEAP_DEPTH)) begin
            res_st <= imhq_pkg::ST_FULL;
            state  <= S_DONE;
          end else begin
            pos    <= HA'(ecount);
            ecount <= ecount + 1'b1;
            state  <= S_UPRD;
          end
        end
        S_POS: state <= S_POS2;
        S_POS2: begin
          pos <= p_rdata;
          if (CW'(p_rdata) < ecount) begin
            state <= S_UPDRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_UPDRD: state <= S_UPDWT;
        S_UPDWT: begin
          if (h_rpr < cpr) begin
            state <= S_DNRD;
          end else begin
            state <= S_UPRD;
          end
        end
        S_UPRD: begin
          if (pos == '0) begin
            state <= S_WRCUR;
          end else begin
            child <= (pos - 1'b1) >> 1;
            state <= S_UPWT;
          end
        end
        S_UPWT: begin
          oth_id <= h_rid;
          oth_pr <= h_rpr;
          state  <= S_UPCMP;
        end
        S_UPCMP: begin
          if (oth_pr > cpr) begin
            pos   <= child;
            state <= S_UPRD;
          end else begin
            state <= S_WRCUR;
          end
        end
        S_DNRD: begin
          if (lc >= ec_ext) begin
            state <= S_WRCUR;
          end else begin
            state <= S_DNRD2;
          end
        end
        S_DNRD2: begin
          l_id  <= h_rid;
          l_pr  <= h_rpr;
          state <= S_DNWT;
        end
        S_DNWT: begin
          if (l_pr < cpr) begin
            if (lc + 1'b1 < ec_ext && h_rpr < l_pr) begin
              child  <= lc[HA-1:0] + 1'b1;
              oth_id <= h_rid;
              oth_pr <= h_rpr;
            end else begin
              child  <= lc[HA-1:0];
              oth_id <= l_id;
              oth_pr <= l_pr;
            end
          end else if (lc + 1'b1 < ec_ext && h_rpr < cpr) begin
            child  <= lc[HA-1:0] + 1'b1;
            oth_id <= h_rid;
            oth_pr <= h_rpr;
          end else begin
            child  <= pos;
            oth_id <= cid;
            oth_pr <= cpr;
          end
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (child != pos) begin
            pos   <= child;
            state <= S_DNRD;
          end else begin
            state <= S_WRCUR;
          end
        end
        S_WRCUR: begin
          state <= S_DONE;
        end
        S_POPRD: state <= S_POPWT;
        S_POPWT: begin
          cid   <= h_rid;
          cpr   <= h_rpr;
          state <= S_POPCAP;
        end
        S_POPCAP: begin
          res_id <= imhq_pkg::ID_W'(h_rid);
          res_pr <= imhq_pkg::PRIO_W'(h_rpr);
          ecount <= ecount - 1'b1;
          pos    <= '0;
          if (ecount == CW'(1)) begin
            state <= S_DONE;
          end else begin
            state <= S_DNRD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            out_id       <= res_id;
            out_priority <= res_pr;
            status       <= res_st;
            count        <= imhq_pkg::COUNT_W'(ecount);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/indexed_min_heap_queue_core.sv
// Top level of the indexed min-heap queue.
//  channel | signals                                   | direction
//  in      | in_valid in_stall action item_id priority_req | into block
//  out     | out_valid out_stall out_id out_priority status count | out of block
// The heap sequencer handles one item at a time: a presence lookup, a position lookup for
// an id already present, a sift up or sift down with registered memory reads on every level,
// and a write-back; the longest case is an update sifted down from the root.
// After reset the presence table is cleared entry by entry; items wait in the queue.
// Input items queue in a four-entry buffer while the heap sequencer works.
// A result holds in its register while out_stall is high; the next result waits for it.
module indexed_min_heap_queue_core #(
  parameter int HEAP_DEPTH     = imhq_pkg::HeapDepth,
  parameter int ID_SPACE       = imhq_pkg::IdSpace,
  parameter int PRIORITY_WIDTH = imhq_pkg::PriorityWidth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [imhq_pkg::ACTION_W-1:0] action,
  input  logic [imhq_pkg::ID_W-1:0]     item_id,
  input  logic [imhq_pkg::PRIO_W-1:0]   priority_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [imhq_pkg::ID_W-1:0]     out_id,
  output logic [imhq_pkg::PRIO_W-1:0]   out_priority,
  output logic [imhq_pkg::STATUS_W-1:0] status,
  output logic [imhq_pkg::COUNT_W-1:0]  count
);
  imhq_pkg::cmd_t in_cmd;
  imhq_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_take;

  assign in_cmd.action       = action;
  assign in_cmd.item_id      = item_id;
  assign in_cmd.priority_req = priority_req;

  imhq_front #(.QUEUE_DEPTH(imhq_pkg::QueueDepth)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  imhq_back #(
    .HEAP_DEPTH(HEAP_DEPTH), .ID_SPACE(ID_SPACE), .PRIORITY_WIDTH(PRIORITY_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_id(out_id),
    .out_priority(out_priority), .status(status), .count(count)
  );
endmodule
